@@ hdl/nlc_pkg.sv @@
`timescale 1ns / 1ps

package nlc_pkg;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_HEX = 2'd1,
      BASE_OCT = 2'd2,
      BASE_BIN = 2'd3
   } base_type;

   typedef enum logic [2:0] {
      STATUS_INT_OK       = 3'd0,
      STATUS_FLOAT_OK     = 3'd1,
      STATUS_MANY_DOTS    = 3'd2,
      STATUS_DOT_IN_INT   = 3'd3,
      STATUS_BAD_DIGIT    = 3'd4,
      STATUS_OUT_OF_RANGE = 3'd5,
      STATUS_BAD_FLOAT    = 3'd6
   } status_type;

   // no error recorded yet shares the code of a clean integer
   localparam status_type ERR_NONE = STATUS_INT_OK;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CHAR_LA    = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_LF    = 8'h66;  // 'f'
   localparam logic [7:0] CHAR_UA    = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_UF    = 8'h46;  // 'F'
   localparam logic [7:0] CHAR_X     = 8'h78;  // 'x'
   localparam logic [7:0] CHAR_O     = 8'h6f;  // 'o'
   localparam logic [7:0] CHAR_B     = 8'h62;  // 'b'
   localparam logic [7:0] CHAR_DOT   = 8'h2e;  // '.'

   // scan state carried from one character to the next
   typedef struct packed {
      base_type    base;
      logic [1:0]  dots;
      status_type  err;
      logic [7:0]  err_char;
      logic [63:0] acc;
      logic        ovf;
      logic        saw;
   } scan_type;

   localparam scan_type SCAN_RESET = '{
      base:     BASE_DEC,
      dots:     2'd0,
      err:      ERR_NONE,
      err_char: 8'd0,
      acc:      64'd0,
      ovf:      1'b0,
      saw:      1'b0
   };

endpackage

@@ hdl/nlc_char_step.sv @@
`timescale 1ns / 1ps

// Apply one character to the scan state.
module nlc_char_step (
   input  nlc_pkg::scan_type cur,
   input  logic [7:0]        char_code,
   output nlc_pkg::scan_type nxt
);

   logic [3:0]  digit;
   logic        is_digit;
   logic        in_radix;
   logic [67:0] prod;
   logic [67:0] sum;

   always_comb begin
      digit    = 4'd0;
      is_digit = 1'b0;
      if (char_code >= nlc_pkg::CHAR_ZERO && char_code <= nlc_pkg::CHAR_NINE) begin
         digit    = 4'(char_code - nlc_pkg::CHAR_ZERO);
         is_digit = 1'b1;
      end else if (char_code >= nlc_pkg::CHAR_LA && char_code <= nlc_pkg::CHAR_LF) begin
         digit    = 4'(char_code - nlc_pkg::CHAR_LA + 8'd10);
         is_digit = 1'b1;
      end else if (char_code >= nlc_pkg::CHAR_UA && char_code <= nlc_pkg::CHAR_UF) begin
         digit    = 4'(char_code - nlc_pkg::CHAR_UA + 8'd10);
         is_digit = 1'b1;
      end
   end

   always_comb begin
      case (cur.base)
         nlc_pkg::BASE_DEC: begin
            in_radix = (digit < 4'd10);
            prod     = {1'b0, cur.acc, 3'b0} + {3'b0, cur.acc, 1'b0};
         end
         nlc_pkg::BASE_HEX: begin
            in_radix = 1'b1;
            prod     = {cur.acc, 4'b0};
         end
         nlc_pkg::BASE_OCT: begin
            in_radix = (digit < 4'd8);
            prod     = {1'b0, cur.acc, 3'b0};
         end
         nlc_pkg::BASE_BIN: begin
            in_radix = (digit < 4'd2);
            prod     = {3'b0, cur.acc, 1'b0};
         end
         default: begin
            in_radix = 1'b0;
            prod     = 68'd0;
         end
      endcase
   end

   assign sum = prod + {64'd0, digit};

   always_comb begin
      nxt = cur;
      if (char_code == nlc_pkg::CHAR_DOT) begin
         if (cur.base == nlc_pkg::BASE_DEC) begin
            if (cur.dots != 2'd2) begin
               nxt.dots = cur.dots + 2'd1;
            end
         end else if (cur.err == nlc_pkg::ERR_NONE) begin
            nxt.err      = nlc_pkg::STATUS_DOT_IN_INT;
            nxt.err_char = 8'd0;
         end
      end else if (!(is_digit && in_radix)) begin
         if (cur.err == nlc_pkg::ERR_NONE) begin
            nxt.err      = nlc_pkg::STATUS_BAD_DIGIT;
            nxt.err_char = char_code;
         end
      end else begin
         nxt.saw = 1'b1;
         if (!cur.ovf) begin
            if (sum[67:64] != 4'd0) begin
               nxt.ovf = 1'b1;
               nxt.acc = '1;
            end else begin
               nxt.acc = sum[63:0];
            end
         end
      end
   end

endmodule

@@ hdl/number_literal_checker.sv @@
`timescale 1ns / 1ps

// Number literal checker. Feed the characters of one literal as items, one
// per cycle, with req_is_last set on the final character; one verdict item
// leaves on the rsp_ side per literal. A literal opening with 0x, 0o or 0b
// and holding at least three characters is read in base 16, 8 or 2;
// anything else is base 10, where a single dot makes it a float. The block
// takes one item every cycle unless a last character waits on a pending
// verdict. The verdict is formed from the last character held in the input
// register by the scan and stored in the result register; the 64-bit
// shift-add with overflow detect in the character step closes the loop on
// the scan state. A pending verdict stalls only the next last-character
// item; others keep flowing.
module number_literal_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_bad_char,
   output logic [63:0] rsp_int_value
);

   // input register
   logic              in_valid_ff;
   logic [7:0]        in_char_ff;
   logic              in_last_ff;

   // scan state
   logic [1:0]        pos_ff,    pos_in;
   logic [7:0]        first_ff,  first_in;
   logic [7:0]        prefix_ff, prefix_in;
   nlc_pkg::scan_type scan_ff,   scan_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [2:0]        status_ff,    status_in;
   logic [7:0]        bad_ff,       bad_in;
   logic [63:0]       value_ff,     value_in;

   nlc_pkg::scan_type step_cur;
   nlc_pkg::scan_type step_nxt;
   nlc_pkg::base_type prefix_base;
   logic              out_free;
   logic              advance;

   // a non-final item never produces a verdict, so it may always advance
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_is_last;
      end
   end

   // base decision, made when the third character arrives
   always_comb begin
      prefix_base = nlc_pkg::BASE_DEC;
      if (first_ff == nlc_pkg::CHAR_ZERO) begin
         if (prefix_ff == nlc_pkg::CHAR_X) begin
            prefix_base = nlc_pkg::BASE_HEX;
         end else if (prefix_ff == nlc_pkg::CHAR_O) begin
            prefix_base = nlc_pkg::BASE_OCT;
         end else if (prefix_ff == nlc_pkg::CHAR_B) begin
            prefix_base = nlc_pkg::BASE_BIN;
         end
      end
   end

   // The first two characters are scanned as base 10 straight away. With a
   // prefix, drop that work at the third character and restart clean in the
   // chosen base; without one, it is exactly what base 10 needs anyway.
   always_comb begin
      step_cur = scan_ff;
      if (pos_ff == 2'd2 && prefix_base != nlc_pkg::BASE_DEC) begin
         step_cur      = nlc_pkg::SCAN_RESET;
         step_cur.base = prefix_base;
      end
   end

   nlc_char_step u_step (
      .cur       (step_cur),
      .char_code (in_char_ff),
      .nxt       (step_nxt)
   );

   // next scan state and verdict
   always_comb begin
      pos_in       = pos_ff;
      first_in     = first_ff;
      prefix_in    = prefix_ff;
      scan_in      = scan_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      status_in    = status_ff;
      bad_in       = bad_ff;
      value_in     = value_ff;

      if (advance) begin
         if (pos_ff == 2'd0) begin
            first_in = in_char_ff;
         end
         if (pos_ff == 2'd1) begin
            prefix_in = in_char_ff;
         end
         if (pos_ff != 2'd3) begin
            pos_in = pos_ff + 2'd1;
         end
         scan_in = step_nxt;

         if (in_last_ff) begin
            out_valid_in = 1'b1;
            bad_in       = 8'd0;
            value_in     = 64'd0;
            if (step_nxt.base == nlc_pkg::BASE_DEC && step_nxt.dots == 2'd2) begin
               status_in = nlc_pkg::STATUS_MANY_DOTS;
            end else if (step_nxt.err != nlc_pkg::ERR_NONE) begin
               status_in = step_nxt.err;
               if (step_nxt.err == nlc_pkg::STATUS_BAD_DIGIT) begin
                  bad_in = step_nxt.err_char;
               end
            end else if (step_nxt.base == nlc_pkg::BASE_DEC && step_nxt.dots == 2'd1) begin
               status_in = step_nxt.saw ? nlc_pkg::STATUS_FLOAT_OK
                                        : nlc_pkg::STATUS_BAD_FLOAT;
            end else if (step_nxt.ovf) begin
               status_in = nlc_pkg::STATUS_OUT_OF_RANGE;
               value_in  = '1;
            end else begin
               status_in = nlc_pkg::STATUS_INT_OK;
               value_in  = step_nxt.acc;
            end
            // clear the scan for the next literal
            pos_in    = 2'd0;
            first_in  = 8'd0;
            prefix_in = 8'd0;
            scan_in   = nlc_pkg::SCAN_RESET;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 2'd0;
         first_ff     <= 8'd0;
         prefix_ff    <= 8'd0;
         scan_ff      <= nlc_pkg::SCAN_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         prefix_ff    <= prefix_in;
         scan_ff      <= scan_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // verdict payload: hold while the item waits
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      bad_ff    <= bad_in;
      value_ff  <= value_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_bad_char  = bad_ff;
   assign rsp_int_value = value_ff;

endmodule
